@@ rtl/t1bre_pkg.sv @@
package t1bre_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned MaxRes = 6;
  localparam int unsigned ResCntW = $clog2(MaxRes + 1);

  localparam logic [1:0] KindPayload = 2'd0;
  localparam logic [1:0] KindTx = 2'd1;
  localparam logic [1:0] KindVerdict = 2'd2;

  localparam logic [1:0] VerdictOk = 2'd0;
  localparam logic [1:0] VerdictRetry = 2'd1;
  localparam logic [1:0] VerdictFail = 2'd2;
  localparam logic [1:0] VerdictMore = 2'd3;

  localparam logic [ByteW-1:0] IfsReset = 8'd32;
  localparam logic [ByteW-1:0] WaitReset = 8'd1;

  localparam logic [ByteW-1:0] RErrNone = 8'h00;
  localparam logic [ByteW-1:0] RErrParity = 8'h01;
  localparam logic [ByteW-1:0] RErrOther = 8'h02;

  localparam int unsigned OutDataW = 32;

  typedef struct packed {
    logic [1:0]       kind;
    logic [ByteW-1:0] value;
    logic [1:0]       verdict;
    logic             lrc_error;
  } res_t;

endpackage

@@ rtl/t1_block_receive_engine.sv @@
// channel   | dir | tdata                                   | tuser   | tlast
// s_axis    | in  | rx_byte[7:0]                            | command | -
// m_axis    | out | value, verdict, lrc_error, wait, ifs    | kind    | last
// cfg       | in  | cfg_wdata_i = node_address              | -       | -
//
// a card byte is parsed in the cycle it is accepted; its results sit in a
// six-entry result buffer that drains one word per cycle while m_axis_tready is high
// payload bytes pass at one word per cycle while m_axis_tready is high; a step
// with n result words (up to six) keeps s_axis_tready low until m_axis is taking its last word
// rst_ni clears the parse state, sequence bits, ifs to 32 and wait to 1
// m_axis stalls back up into s_axis once the buffer holds more than one word, or one word m_axis is not taking
module t1_block_receive_engine
  import t1bre_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [ByteW-1:0]    s_axis_tdata,   // rx_byte
  input  logic                s_axis_tuser,   // command
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // value[7:0], verdict[9:8], lrc_error[10], wait_factor[18:11], card_ifs[26:19]
  output logic [OutDataW-1:0] m_axis_tdata,
  output logic [1:0]          m_axis_tuser,   // kind
  output logic                m_axis_tlast,
  input  logic                cfg_we_i,
  input  logic [ByteW-1:0]    cfg_wdata_i
);

  localparam logic [2:0] PhNad = 3'd0;
  localparam logic [2:0] PhPcb = 3'd1;
  localparam logic [2:0] PhLen = 3'd2;
  localparam logic [2:0] PhData = 3'd3;
  localparam logic [2:0] PhLrc = 3'd4;

  logic [2:0]       phase_q, phase_d;
  logic [ByteW-1:0] lrc_q, lrc_d;
  logic [ByteW-1:0] ctrl_q, ctrl_d;
  logic [ByteW-1:0] rem_q, rem_d;
  logic [ByteW-1:0] sdat_q, sdat_d;
  logic             rseq_q, rseq_d;
  logic             sseq_q, sseq_d;
  logic [ByteW-1:0] ifs_q, ifs_d;
  logic [ByteW-1:0] wait_q, wait_d;
  logic [ByteW-1:0] nad_q;

  res_t             res_q [MaxRes];
  res_t             res_d [MaxRes];
  logic [ResCntW-1:0] cnt_q, cnt_d;
  logic [ByteW-1:0] out_wait_q, out_wait_d;
  logic [ByteW-1:0] out_ifs_q, out_ifs_d;

  logic             accept, pop;
  logic [ByteW-1:0] b;
  logic             is_i, is_s;
  logic [ByteW-1:0] tx [4];
  logic [2:0]       tx_len;
  logic [ByteW-1:0] tx_lrc;
  logic [1:0]       vcode;
  logic             verr;
  logic             has_verdict;
  logic             has_payload;
  logic [ByteW-1:0] rem_dec;
  logic             match;
  logic [1:0]       stype;
  logic             slen;
  logic [ResCntW-1:0] vidx;
  logic [ResCntW-1:0] n_res;

  assign b = s_axis_tdata;
  assign is_i = ~ctrl_q[7];
  assign is_s = ctrl_q[7] & ctrl_q[6];
  assign rem_dec = rem_q - 8'd1;
  assign match = (ctrl_q[6] == rseq_q);

  assign m_axis_tvalid = (cnt_q != '0);
  assign pop = m_axis_tvalid & m_axis_tready;
  assign s_axis_tready = (cnt_q == '0) | ((cnt_q == ResCntW'(1)) & m_axis_tready);
  assign accept = s_axis_tvalid & s_axis_tready;

  always_comb begin
    phase_d = phase_q;
    lrc_d = lrc_q;
    ctrl_d = ctrl_q;
    rem_d = rem_q;
    sdat_d = sdat_q;
    rseq_d = rseq_q;
    sseq_d = sseq_q;
    ifs_d = ifs_q;
    wait_d = wait_q;
    tx[0] = nad_q;
    tx[1] = '0;
    tx[2] = '0;
    tx[3] = sdat_q;
    tx_len = 3'd0;
    vcode = VerdictOk;
    verr = 1'b0;
    has_verdict = 1'b0;
    has_payload = 1'b0;
    stype = 2'd0;
    slen = 1'b0;
    if (s_axis_tuser) begin
      sseq_d = ~sseq_q;
    end else begin
      unique case (phase_q)
        PhPcb: begin
          ctrl_d = b;
          sdat_d = '0;
          lrc_d = lrc_q ^ b;
          phase_d = PhLen;
        end
        PhLen: begin
          lrc_d = lrc_q ^ b;
          rem_d = (is_i | is_s) ? b : '0;
          phase_d = ((is_i | is_s) && b != '0) ? PhData : PhLrc;
        end
        PhData: begin
          lrc_d = lrc_q ^ b;
          if (is_i) begin
            has_payload = 1'b1;
          end else begin
            sdat_d = b;
          end
          rem_d = rem_dec;
          if (rem_dec == '0) begin
            phase_d = PhLrc;
          end
        end
        PhLrc: begin
          phase_d = PhNad;
          has_verdict = 1'b1;
          if (lrc_q != b) begin
            tx[1] = 8'h80 | RErrParity | {3'd0, rseq_q, 4'd0};
            tx_len = 3'd3;
            vcode = VerdictMore;
            verr = 1'b1;
          end else if (is_i) begin
            rseq_d = rseq_q ^ match;
            if (ctrl_q[5] | ~match) begin
              tx[1] = 8'h80 | (match ? RErrNone : RErrOther) | {3'd0, rseq_d, 4'd0};
              tx_len = 3'd3;
              vcode = VerdictMore;
            end
          end else if (is_s) begin
            vcode = ctrl_q[5] ? VerdictOk : VerdictMore;
            if (ctrl_q[1:0] == 2'b11) begin
              wait_d = sdat_q;
              stype = 2'd3;
              slen = 1'b1;
            end else if (ctrl_q[1]) begin
              stype = 2'd2;
              vcode = VerdictFail;
            end else if (ctrl_q[0]) begin
              if (!ctrl_q[5]) begin
                ifs_d = sdat_q;
              end
              stype = 2'd1;
              slen = 1'b1;
            end else begin
              rseq_d = 1'b0;
              sseq_d = 1'b0;
            end
            if (!ctrl_q[5]) begin
              tx[1] = {6'b111000, stype};
              tx[2] = {7'd0, slen};
              tx_len = slen ? 3'd4 : 3'd3;
            end
          end else begin
            vcode = (ctrl_q[3:0] != 4'd0 || ctrl_q[4] != ~sseq_q) ? VerdictRetry : VerdictOk;
          end
        end
        default: begin
          wait_d = WaitReset;
          lrc_d = b;
          phase_d = PhPcb;
        end
      endcase
    end
  end

  assign tx_lrc = tx[0] ^ tx[1] ^ tx[2] ^ ((tx_len == 3'd4) ? tx[3] : '0);
  assign vidx = (tx_len == 3'd0) ? '0 : ResCntW'(tx_len + 3'd1);
  assign n_res = has_payload ? ResCntW'(1) : (has_verdict ? vidx + ResCntW'(1) : '0);

  always_comb begin
    for (int i = 0; i < MaxRes; i++) begin
      res_d[i] = (pop && i + 1 < MaxRes) ? res_q[(i + 1) % MaxRes] : res_q[i];
    end
    cnt_d = pop ? cnt_q - ResCntW'(1) : cnt_q;
    out_wait_d = out_wait_q;
    out_ifs_d = out_ifs_q;
    if (accept && n_res != '0) begin
      cnt_d = n_res;
      out_wait_d = wait_d;
      out_ifs_d = ifs_d;
      for (int i = 0; i < MaxRes; i++) begin
        res_d[i] = '{kind: KindTx, value: '0, verdict: VerdictOk, lrc_error: 1'b0};
        if (has_payload) begin
          if (i == 0) begin
            res_d[i].kind = KindPayload;
            res_d[i].value = b;
          end
        end else if (ResCntW'(i) < ResCntW'(tx_len)) begin
          res_d[i].value = tx[i % 4];
        end else if (ResCntW'(i) == ResCntW'(tx_len) && tx_len != 3'd0) begin
          res_d[i].value = tx_lrc;
        end else if (ResCntW'(i) == vidx) begin
          res_d[i].kind = KindVerdict;
          res_d[i].verdict = vcode;
          res_d[i].lrc_error = verr;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhNad;
      lrc_q <= '0;
      ctrl_q <= '0;
      rem_q <= '0;
      sdat_q <= '0;
      rseq_q <= 1'b0;
      sseq_q <= 1'b0;
      ifs_q <= IfsReset;
      wait_q <= WaitReset;
      nad_q <= '0;
      cnt_q <= '0;
    end else begin
      if (cfg_we_i) begin
        nad_q <= cfg_wdata_i;
      end
      if (accept) begin
        phase_q <= phase_d;
        lrc_q <= lrc_d;
        ctrl_q <= ctrl_d;
        rem_q <= rem_d;
        sdat_q <= sdat_d;
        rseq_q <= rseq_d;
        sseq_q <= sseq_d;
        ifs_q <= ifs_d;
        wait_q <= wait_d;
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    out_wait_q <= out_wait_d;
    out_ifs_q <= out_ifs_d;
  end

  assign m_axis_tuser = res_q[0].kind;
  assign m_axis_tlast = (cnt_q == ResCntW'(1));
  assign m_axis_tdata = {5'd0, out_ifs_q, out_wait_q, res_q[0].lrc_error,
                         res_q[0].verdict, res_q[0].value};

endmodule

@@ rtl/t1bre_checker.sv @@
module t1bre_checker
  import t1bre_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic [1:0]          m_axis_tuser,
  input logic                m_axis_tlast
);

  // a non-verdict word carries no verdict and no lrc flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != KindVerdict |-> m_axis_tdata[10:8] == 3'd0)
    else $error("verdict bits set on a non-verdict word");

  // a verdict word has a zero value and always closes the run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KindVerdict |->
      m_axis_tdata[7:0] == 8'd0 && m_axis_tlast)
    else $error("verdict word malformed");

  // kind code three is never produced
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser != 2'd3)
    else $error("unknown kind");

  // a stalled output word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled output word changed");

  // no new input while more than the final word of a run is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("input taken while a reply is pending");

endmodule

bind t1_block_receive_engine t1bre_checker u_t1bre_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

@@ verif/t1_block_receive_engine_tb.sv @@
module t1_block_receive_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import t1bre_pkg::*;

  localparam int HoldCycles = 300;
  localparam int SettleCycles = 16;
  localparam int DrainLimit = 50000;

  typedef enum logic [2:0] {PhNad, PhPcb, PhLen, PhData, PhLrc} parse_phase_e;
  typedef enum logic [1:0] {SResynch, SIfs, SAbort, SWtx} s_type_e;

  typedef struct packed {
    logic       cmd;
    logic [7:0] rx;
  } card_item_t;

  typedef struct {
    logic [1:0] kind;
    logic [7:0] value;
    logic       last;
    logic [1:0] verdict;
    logic       lrc_err;
    logic [7:0] wtx;
    logic [7:0] ifs;
  } engine_word_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [ByteW-1:0]    s_axis_tdata;
  logic                s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [1:0]          m_axis_tuser;
  logic                m_axis_tlast;
  logic                cfg_we_i;
  logic [ByteW-1:0]    cfg_wdata_i;

  // block tracking state
  parse_phase_e ph;
  logic [7:0]   lrc_acc;
  logic [7:0]   pcb_q;
  logic [7:0]   remain;
  logic [7:0]   s_datum;
  logic [7:0]   nad_q;
  logic [7:0]   ifs_q;
  logic [7:0]   wtx_q;
  logic         nr;
  logic         ns;

  card_item_t   card_bytes[$];
  card_item_t   cur;
  engine_word_t step_words[$];
  engine_word_t due_words[$];

  int fails = 0;
  int n_pushed = 0;
  int n_items = 0;
  int n_words = 0;
  int n_verdicts = 0;
  int n_lrc = 0;
  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  int hold_reqs = 0;
  int hold_done = 0;
  int hold_left = 0;
  logic [7:0] last_nad;

  t1_block_receive_engine u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic put_word(input logic [1:0] k, input logic [7:0] v, input logic [1:0] vd,
                          input logic le);
    engine_word_t w;
    w.kind = k;
    w.value = v;
    w.last = 1'b0;
    w.verdict = vd;
    w.lrc_err = le;
    w.wtx = wtx_q;
    w.ifs = ifs_q;
    step_words.push_back(w);
  endtask

  // reply block bytes packed lowest first, followed by their xor
  task automatic put_reply(input logic [31:0] bytes, input int n);
    logic [7:0] x;
    x = 8'h00;
    for (int i = 0; i < n; i++) begin
      put_word(KindTx, bytes[8*i+:8], VerdictOk, 1'b0);
      x ^= bytes[8*i+:8];
    end
    put_word(KindTx, x, VerdictOk, 1'b0);
  endtask

  task automatic put_r_block(input logic [7:0] err);
    put_reply({8'h00, 8'h00, 8'h80 | err | {3'b000, nr, 4'b0000}, nad_q}, 3);
  endtask

  task automatic settle_block(output logic [1:0] vd);
    logic    match;
    logic    resp;
    s_type_e st;
    int      len;
    if (!pcb_q[7]) begin
      match = (pcb_q[6] == nr);
      if (match) nr = ~nr;
      if (pcb_q[5] || !match) begin
        put_r_block(match ? RErrNone : RErrOther);
        vd = VerdictMore;
      end else begin
        vd = VerdictOk;
      end
    end else if (pcb_q[7:6] == 2'b11) begin
      resp = pcb_q[5];
      vd = resp ? VerdictOk : VerdictMore;
      if (pcb_q[1:0] == 2'b11) begin
        wtx_q = s_datum;
        st = SWtx;
        len = 1;
      end else if (pcb_q[1]) begin
        st = SAbort;
        len = 0;
        vd = VerdictFail;
      end else if (pcb_q[0]) begin
        if (!resp) ifs_q = s_datum;
        st = SIfs;
        len = 1;
      end else begin
        st = SResynch;
        len = 0;
        nr = 1'b0;
        ns = 1'b0;
      end
      if (!resp) put_reply({s_datum, 8'(len), 8'hE0 | 8'(st), nad_q}, 3 + len);
    end else if (pcb_q[3:0] != 4'h0 || pcb_q[4] != ~ns) begin
      vd = VerdictRetry;
    end else begin
      vd = VerdictOk;
    end
  endtask

  task automatic track_engine(input card_item_t it);
    logic [1:0] vd;
    step_words.delete();
    if (it.cmd) begin
      ns = ~ns;
      return;
    end
    case (ph)
      PhPcb: begin
        pcb_q = it.rx;
        s_datum = 8'h00;
        lrc_acc ^= it.rx;
        ph = PhLen;
      end
      PhLen: begin
        lrc_acc ^= it.rx;
        remain = (!pcb_q[7] || pcb_q[6]) ? it.rx : 8'h00;
        ph = (remain != 8'h00) ? PhData : PhLrc;
      end
      PhData: begin
        lrc_acc ^= it.rx;
        if (!pcb_q[7]) put_word(KindPayload, it.rx, VerdictOk, 1'b0);
        else s_datum = it.rx;
        remain = remain - 8'd1;
        if (remain == 8'h00) ph = PhLrc;
      end
      PhLrc: begin
        ph = PhNad;
        if (lrc_acc != it.rx) begin
          put_r_block(RErrParity);
          put_word(KindVerdict, 8'h00, VerdictMore, 1'b1);
        end else begin
          settle_block(vd);
          put_word(KindVerdict, 8'h00, vd, 1'b0);
        end
      end
      default: begin
        wtx_q = WaitReset;
        lrc_acc = it.rx;
        ph = PhPcb;
      end
    endcase
    if (step_words.size() > 0) step_words[$].last = 1'b1;
    foreach (step_words[i]) due_words.push_back(step_words[i]);
  endtask

  // card side driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      s_axis_tuser <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        track_engine(cur);
        n_items++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (card_bytes.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
          cur = card_bytes.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= cur.rx;
          s_axis_tuser <= cur.cmd;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result side ready, with the long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (hold_done != hold_reqs) begin
      hold_done++;
      hold_left = HoldCycles;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  task automatic cmp_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i) begin
    engine_word_t w;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_words++;
      if (m_axis_tuser == KindVerdict) n_verdicts++;
      if (m_axis_tdata[10]) n_lrc++;
      if (due_words.size() == 0) begin
        $error("unexpected word: kind %0h value %0h", m_axis_tuser, m_axis_tdata[7:0]);
        fails++;
      end else begin
        w = due_words.pop_front();
        cmp_field("kind", 8'(w.kind), 8'(m_axis_tuser));
        cmp_field("value", w.value, m_axis_tdata[7:0]);
        cmp_field("last", 8'(w.last), 8'(m_axis_tlast));
        cmp_field("verdict", 8'(w.verdict), 8'(m_axis_tdata[9:8]));
        cmp_field("lrc_error", 8'(w.lrc_err), 8'(m_axis_tdata[10]));
        cmp_field("wait_factor", w.wtx, m_axis_tdata[18:11]);
        cmp_field("card_ifs", w.ifs, m_axis_tdata[26:19]);
      end
    end
  end

  task automatic queue_item(input logic cmd, input logic [7:0] b);
    card_item_t it;
    it.cmd = cmd;
    it.rx = b;
    card_bytes.push_back(it);
    n_pushed++;
  endtask

  // fill < 0 gives random payload bytes
  task automatic queue_block(input logic [7:0] pcb, input int len, input int fill,
                             input logic bad_lrc);
    logic [7:0] nad;
    logic [7:0] x;
    logic [7:0] b;
    nad = 8'($urandom_range(0, 255));
    queue_item(1'b0, nad);
    queue_item(1'b0, pcb);
    queue_item(1'b0, 8'(len));
    x = nad ^ pcb ^ 8'(len);
    if (!pcb[7] || pcb[6]) begin
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 39) == 0) queue_item(1'b1, 8'($urandom_range(0, 255)));
        b = (fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill);
        queue_item(1'b0, b);
        x ^= b;
      end
    end
    if (bad_lrc) x ^= 8'($urandom_range(1, 255));
    queue_item(1'b0, x);
  endtask

  task automatic queue_random(input int target);
    int         stop;
    int         pick;
    int         len;
    logic [7:0] pcb;
    stop = n_pushed + target;
    while (n_pushed < stop) begin
      pick = $urandom_range(0, 99);
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 4);
      if (pick < 6) begin
        repeat ($urandom_range(1, 4)) begin
          queue_item($urandom_range(0, 3) == 0, 8'($urandom_range(0, 255)));
        end
      end else if (pick < 45) begin
        pcb = {1'b0, 7'($urandom_range(0, 127))};
        queue_block(pcb, len, -1, $urandom_range(0, 9) == 0);
      end else if (pick < 75) begin
        pcb = {2'b11, 6'($urandom_range(0, 63))};
        queue_block(pcb, $urandom_range(0, 2), -1, $urandom_range(0, 9) == 0);
      end else begin
        if ($urandom_range(0, 3) == 0) pcb = {2'b10, 6'($urandom_range(0, 63))};
        else pcb = {3'b100, 1'($urandom_range(0, 1)), 4'h0};
        len = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 255) : 0;
        queue_block(pcb, len, -1, $urandom_range(0, 9) == 0);
      end
      if ($urandom_range(0, 9) == 0) queue_item(1'b1, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic wait_drained();
    int n;
    n = 0;
    do begin
      @(posedge clk_i);
      n++;
    end while ((n_items != n_pushed || due_words.size() != 0) && n < DrainLimit);
    if (due_words.size() != 0) begin
      $error("%0d expected words never arrived", due_words.size());
      fails++;
      due_words.delete();
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_nad(input logic [7:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    nad_q = v;
    last_nad = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    ph = PhNad;
    lrc_acc = 8'h00;
    pcb_q = 8'h00;
    remain = 8'h00;
    s_datum = 8'h00;
    nad_q = 8'h00;
    ifs_q = IfsReset;
    wtx_q = WaitReset;
    nr = 1'b0;
    ns = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // sender idles 37, receiver 59
    write_nad(8'hFF);
    src_idle_pct = 37;
    snk_idle_pct = 59;
    queue_item(1'b1, 8'hFF);
    queue_block(8'h00, 2, 8'hFF, 1'b0);
    queue_block(8'h20, 1, 8'h00, 1'b0);
    queue_block(8'hC3, 1, 8'hFF, 1'b0);
    queue_block(8'h80, 2, -1, 1'b1);
    queue_block(8'hC1, 0, -1, 1'b0);
    queue_random(65);
    wait_drained();

    // sender idles 59, receiver 37
    write_nad(8'h00);
    src_idle_pct = 59;
    snk_idle_pct = 37;
    queue_random(65);
    wait_drained();

    // no idling, receiver holds off while the sender keeps offering
    write_nad(8'($urandom_range(1, 254)));
    src_idle_pct = 0;
    snk_idle_pct = 0;
    hold_reqs++;
    queue_random(65);
    wait_drained();

    $display("%0d card words in, %0d result words checked, %0d verdicts, %0d lrc errors",
             n_items, n_words, n_verdicts, n_lrc);
    $display("node address 0xff, 0x00 and 0x%0h, with one %0d-cycle receiver hold-off",
             last_nad, HoldCycles);
    if (fails == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/t1bre_pkg.sv
rtl/t1_block_receive_engine.sv
rtl/t1bre_checker.sv
verif/t1_block_receive_engine_tb.sv
